@@ hw/rtl/sqt_pkg.sv @@
// ----------------------------------------------------------------------------
// sqt_pkg: shared types and constants of the SQL query tokenizer
// Token kinds, error codes, scanner modes, beat payloads and keyword table.
// ----------------------------------------------------------------------------
package sqt_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int TEXT_W            = 16;
  localparam int NUM_W             = 31;
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
  localparam int KW_COUNT          = 10;
  localparam int KW_BYTES          = 6;
  localparam int KW_W              = 8 * KW_BYTES;
  localparam int OUT_DEPTH         = 4;
  localparam int OUT_PTR_W         = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W         = $clog2(OUT_DEPTH + 1);

  typedef enum logic [4:0] {
    KIND_SELECT = 5'd0,
    KIND_INSERT = 5'd1,
    KIND_FROM   = 5'd2,
    KIND_WHERE  = 5'd3,
    KIND_VALUES = 5'd4,
    KIND_INTO   = 5'd5,
    KIND_CREATE = 5'd6,
    KIND_TABLE  = 5'd7,
    KIND_STRING = 5'd8,
    KIND_INT    = 5'd9,
    KIND_IDENT  = 5'd10,
    KIND_NUMBER = 5'd11,
    KIND_SEMI   = 5'd12,
    KIND_COMMA  = 5'd13,
    KIND_STAR   = 5'd14,
    KIND_LPAREN = 5'd15,
    KIND_RPAREN = 5'd16,
    KIND_NE     = 5'd17,
    KIND_GT     = 5'd18,
    KIND_GE     = 5'd19,
    KIND_LT     = 5'd20,
    KIND_LE     = 5'd21,
    KIND_EQ     = 5'd22,
    KIND_ERROR  = 5'd23,
    KIND_END    = 5'd24
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_SYMBOL     = 2'd1,
    ERR_UNTERM_STR = 2'd2,
    ERR_UNEXPECTED = 2'd3
  } err_e;

  typedef enum logic [8:0] {
    MODE_IDLE   = 9'b000000001,
    MODE_IDENT  = 9'b000000010,
    MODE_NUMBER = 9'b000000100,
    MODE_DQ     = 9'b000001000,
    MODE_SQ     = 9'b000010000,
    MODE_BANG   = 9'b000100000,
    MODE_GT     = 9'b001000000,
    MODE_LT     = 9'b010000000,
    MODE_EQ     = 9'b100000000
  } mode_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } source_t;

  typedef struct packed {
    kind_e             token_kind;
    logic [TEXT_W-1:0] text_start;
    logic [TEXT_W-1:0] text_length;
    logic [NUM_W-1:0]  number_value;
    err_e              error_code;
    logic              last_of_run;
  } token_t;

  // Up to two tokens produced by one source beat.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  // Keyword text, first letter in the low byte, zero padded.
  function automatic logic [KW_W-1:0] kw_text(input int unsigned k);
    logic [KW_W-1:0] t;
    case (k)
      0:       t = 48'h74_63_65_6c_65_73; // select
      1:       t = 48'h74_72_65_73_6e_69; // insert
      2:       t = 48'h00_00_6d_6f_72_66; // from
      3:       t = 48'h00_65_72_65_68_77; // where
      4:       t = 48'h73_65_75_6c_61_76; // values
      5:       t = 48'h00_00_6f_74_6e_69; // into
      6:       t = 48'h65_74_61_65_72_63; // create
      7:       t = 48'h00_65_6c_62_61_74; // table
      8:       t = 48'h67_6e_69_72_74_73; // string
      9:       t = 48'h00_00_00_74_6e_69; // int
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input int unsigned k);
    logic [2:0] n;
    case (k)
      0, 1, 4, 6, 8: n = 3'd6;
      3, 7:          n = 3'd5;
      2, 5:          n = 3'd4;
      9:             n = 3'd3;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic kind_e word_kind(input logic [KW_W-1:0] letters,
                                      input logic [2:0]      count,
                                      input logic            overflow);
    kind_e k;
    k = KIND_IDENT;
    if (!overflow) begin
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
        if (letters == kw_text(i) && count == kw_len(i)) begin
          k = kind_e'(5'(i));
        end
      end
    end
    return k;
  endfunction

endpackage

@@ hw/rtl/sqt_scanner.sv @@
// ----------------------------------------------------------------------------
// sqt_scanner: token scanner
// Holds the pending token state and turns one source beat into up to two
// tokens in the same cycle as the beat.
// ----------------------------------------------------------------------------
module sqt_scanner #(
  parameter int POSITION_BITS = sqt_pkg::POSITION_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  sqt_pkg::source_t item_i,
  output sqt_pkg::push_t   push_o
);

  localparam int PB = POSITION_BITS;
  localparam int TW = sqt_pkg::TEXT_W;
  localparam int NW = sqt_pkg::NUM_W;
  localparam int KW = sqt_pkg::KW_W;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;

  sqt_pkg::mode_e  mode_q, mode_d;
  logic [PB-1:0]   pos_q, pos_d;
  logic [PB-1:0]   start_q, start_d;
  logic [NW-1:0]   acc_q, acc_d;
  logic [KW-1:0]   letters_q, letters_d;
  logic [2:0]      lcnt_q, lcnt_d;
  logic            ovf_q, ovf_d;

  logic [7:0]      b;
  logic [7:0]      b_lower;
  logic            is_digit, is_alpha;
  logic [PB-1:0]   span, str_start, str_len, one, two;
  logic [NW+3:0]   acc_wide;
  logic [NW-1:0]   acc_next;
  sqt_pkg::kind_e  wkind;
  sqt_pkg::token_t e0, e1;
  logic            e0_v, e1_v, consumed;

  function automatic sqt_pkg::token_t mk_tok(input sqt_pkg::kind_e k,
                                             input logic [PB-1:0]  st,
                                             input logic [PB-1:0]  len,
                                             input logic [NW-1:0]  num,
                                             input sqt_pkg::err_e  err);
    sqt_pkg::token_t t;
    t.token_kind   = k;
    t.text_start   = TW'(st);
    t.text_length  = TW'(len);
    t.number_value = num;
    t.error_code   = err;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  assign b         = item_i.source_byte;
  assign is_digit  = (b >= 8'h30) && (b <= 8'h39);
  assign is_alpha  = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  assign b_lower   = ((b >= 8'h41) && (b <= 8'h5a)) ? (b | 8'h20) : b;
  assign one       = PB'(1);
  assign two       = PB'(2);
  assign span      = pos_q - start_q;
  assign str_start = start_q + one;
  assign str_len   = span - one;
  assign wkind     = sqt_pkg::word_kind(letters_q, lcnt_q, ovf_q);
  assign acc_wide  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (NW+4)'(b[3:0]);
  assign acc_next  = (acc_wide > (NW+4)'(sqt_pkg::NUM_MAX)) ? sqt_pkg::NUM_MAX
                                                           : acc_wide[NW-1:0];

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    start_d   = start_q;
    acc_d     = acc_q;
    letters_d = letters_q;
    lcnt_d    = lcnt_q;
    ovf_d     = ovf_q;
    e0        = '0;
    e1        = '0;
    e0_v      = 1'b0;
    e1_v      = 1'b0;
    consumed  = 1'b0;

    if (fire_i && item_i.end_of_source) begin
      // flush whatever is pending, then close the text
      e0_v = 1'b1;
      case (mode_q)
        sqt_pkg::MODE_IDENT:
          e0 = mk_tok(wkind, start_q, span, '0, sqt_pkg::ERR_NONE);
        sqt_pkg::MODE_NUMBER:
          e0 = mk_tok(sqt_pkg::KIND_NUMBER, start_q, span, acc_q, sqt_pkg::ERR_NONE);
        sqt_pkg::MODE_DQ, sqt_pkg::MODE_SQ:
          e0 = mk_tok(sqt_pkg::KIND_ERROR, start_q, span, '0, sqt_pkg::ERR_UNTERM_STR);
        sqt_pkg::MODE_BANG:
          e0 = mk_tok(sqt_pkg::KIND_ERROR, start_q, one, '0, sqt_pkg::ERR_SYMBOL);
        sqt_pkg::MODE_GT:
          e0 = mk_tok(sqt_pkg::KIND_GT, start_q, one, '0, sqt_pkg::ERR_NONE);
        sqt_pkg::MODE_LT:
          e0 = mk_tok(sqt_pkg::KIND_LT, start_q, one, '0, sqt_pkg::ERR_NONE);
        sqt_pkg::MODE_EQ:
          e0 = mk_tok(sqt_pkg::KIND_EQ, start_q, one, '0, sqt_pkg::ERR_NONE);
        default:
          e0_v = 1'b0;
      endcase
      e1_v      = 1'b1;
      e1        = mk_tok(sqt_pkg::KIND_END, pos_q, '0, '0, sqt_pkg::ERR_NONE);
      mode_d    = sqt_pkg::MODE_IDLE;
      pos_d     = '0;
      start_d   = '0;
      acc_d     = '0;
      letters_d = '0;
      lcnt_d    = '0;
      ovf_d     = 1'b0;
    end else if (fire_i) begin
      case (mode_q)
        sqt_pkg::MODE_IDENT: begin
          if (is_alpha || is_digit) begin
            consumed = 1'b1;
            if (lcnt_q < 3'd6) begin
              letters_d[{lcnt_q, 3'b000} +: 8] = b_lower;
              lcnt_d = lcnt_q + 3'd1;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            e0_v   = 1'b1;
            e0     = mk_tok(wkind, start_q, span, '0, sqt_pkg::ERR_NONE);
            mode_d = sqt_pkg::MODE_IDLE;
          end
        end
        sqt_pkg::MODE_NUMBER: begin
          if (is_digit) begin
            consumed = 1'b1;
            acc_d    = acc_next;
          end else begin
            e0_v   = 1'b1;
            e0     = mk_tok(sqt_pkg::KIND_NUMBER, start_q, span, acc_q, sqt_pkg::ERR_NONE);
            mode_d = sqt_pkg::MODE_IDLE;
          end
        end
        sqt_pkg::MODE_DQ, sqt_pkg::MODE_SQ: begin
          consumed = 1'b1;
          if ((mode_q == sqt_pkg::MODE_DQ && b == CH_DQ) ||
              (mode_q == sqt_pkg::MODE_SQ && b == CH_SQ)) begin
            e0_v   = 1'b1;
            e0     = mk_tok(sqt_pkg::KIND_IDENT, str_start, str_len, '0, sqt_pkg::ERR_NONE);
            mode_d = sqt_pkg::MODE_IDLE;
          end
        end
        sqt_pkg::MODE_BANG: begin
          e0_v   = 1'b1;
          mode_d = sqt_pkg::MODE_IDLE;
          if (b == CH_EQ) begin
            consumed = 1'b1;
            e0 = mk_tok(sqt_pkg::KIND_NE, start_q, two, '0, sqt_pkg::ERR_NONE);
          end else begin
            e0 = mk_tok(sqt_pkg::KIND_ERROR, start_q, one, '0, sqt_pkg::ERR_SYMBOL);
          end
        end
        sqt_pkg::MODE_GT: begin
          e0_v   = 1'b1;
          mode_d = sqt_pkg::MODE_IDLE;
          if (b == CH_EQ) begin
            consumed = 1'b1;
            e0 = mk_tok(sqt_pkg::KIND_GE, start_q, two, '0, sqt_pkg::ERR_NONE);
          end else begin
            e0 = mk_tok(sqt_pkg::KIND_GT, start_q, one, '0, sqt_pkg::ERR_NONE);
          end
        end
        sqt_pkg::MODE_LT: begin
          e0_v   = 1'b1;
          mode_d = sqt_pkg::MODE_IDLE;
          if (b == CH_EQ) begin
            consumed = 1'b1;
            e0 = mk_tok(sqt_pkg::KIND_LE, start_q, two, '0, sqt_pkg::ERR_NONE);
          end else begin
            e0 = mk_tok(sqt_pkg::KIND_LT, start_q, one, '0, sqt_pkg::ERR_NONE);
          end
        end
        sqt_pkg::MODE_EQ: begin
          // a second '=' reports the first as an error and starts afresh
          e0_v   = 1'b1;
          mode_d = sqt_pkg::MODE_IDLE;
          if (b == CH_EQ) begin
            e0 = mk_tok(sqt_pkg::KIND_ERROR, start_q, one, '0, sqt_pkg::ERR_SYMBOL);
          end else begin
            e0 = mk_tok(sqt_pkg::KIND_EQ, start_q, one, '0, sqt_pkg::ERR_NONE);
          end
        end
        default: begin
          mode_d = sqt_pkg::MODE_IDLE;
        end
      endcase

      if (!consumed) begin
        mode_d = sqt_pkg::MODE_IDLE;
        case (b)
          CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
          CH_SEMI: begin
            e1_v = 1'b1;
            e1   = mk_tok(sqt_pkg::KIND_SEMI, pos_q, one, '0, sqt_pkg::ERR_NONE);
          end
          CH_COMMA: begin
            e1_v = 1'b1;
            e1   = mk_tok(sqt_pkg::KIND_COMMA, pos_q, one, '0, sqt_pkg::ERR_NONE);
          end
          CH_STAR: begin
            e1_v = 1'b1;
            e1   = mk_tok(sqt_pkg::KIND_STAR, pos_q, one, '0, sqt_pkg::ERR_NONE);
          end
          CH_LPAR: begin
            e1_v = 1'b1;
            e1   = mk_tok(sqt_pkg::KIND_LPAREN, pos_q, one, '0, sqt_pkg::ERR_NONE);
          end
          CH_RPAR: begin
            e1_v = 1'b1;
            e1   = mk_tok(sqt_pkg::KIND_RPAREN, pos_q, one, '0, sqt_pkg::ERR_NONE);
          end
          CH_BANG: begin
            mode_d  = sqt_pkg::MODE_BANG;
            start_d = pos_q;
          end
          CH_GT: begin
            mode_d  = sqt_pkg::MODE_GT;
            start_d = pos_q;
          end
          CH_LT: begin
            mode_d  = sqt_pkg::MODE_LT;
            start_d = pos_q;
          end
          CH_EQ: begin
            mode_d  = sqt_pkg::MODE_EQ;
            start_d = pos_q;
          end
          CH_DQ: begin
            mode_d  = sqt_pkg::MODE_DQ;
            start_d = pos_q;
          end
          CH_SQ: begin
            mode_d  = sqt_pkg::MODE_SQ;
            start_d = pos_q;
          end
          default: begin
            if (is_digit) begin
              mode_d  = sqt_pkg::MODE_NUMBER;
              start_d = pos_q;
              acc_d   = NW'(b[3:0]);
            end else if (is_alpha) begin
              mode_d    = sqt_pkg::MODE_IDENT;
              start_d   = pos_q;
              letters_d = KW'(b_lower);
              lcnt_d    = 3'd1;
              ovf_d     = 1'b0;
            end else begin
              e1_v = 1'b1;
              e1   = mk_tok(sqt_pkg::KIND_ERROR, pos_q, one, '0, sqt_pkg::ERR_UNEXPECTED);
            end
          end
        endcase
      end
      pos_d = pos_q + one;
    end
  end

  // pack the tokens in order and flag the last one of the beat
  always_comb begin
    push_o        = '0;
    push_o.count  = {1'b0, e0_v} + {1'b0, e1_v};
    if (e0_v) begin
      push_o.first  = e0;
      push_o.second = e1;
      if (e1_v) begin
        push_o.second.last_of_run = 1'b1;
      end else begin
        push_o.first.last_of_run = 1'b1;
      end
    end else begin
      push_o.first             = e1;
      push_o.first.last_of_run = e1_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sqt_pkg::MODE_IDLE;
      pos_q     <= '0;
      start_q   <= '0;
      acc_q     <= '0;
      letters_q <= '0;
      lcnt_q    <= '0;
      ovf_q     <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      acc_q     <= acc_d;
      letters_q <= letters_d;
      lcnt_q    <= lcnt_d;
      ovf_q     <= ovf_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.end_of_source |=> pos_q == '0 && mode_q == sqt_pkg::MODE_IDLE)
    else $error("scan state not cleared after end of source");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.end_of_source |-> push_o.count != 2'd0)
    else $error("end of source produced no token");

  a_lcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcnt_q <= 3'd6)
    else $error("keyword letter count out of range");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |-> push_o.count == 2'd0 ##1 $stable(pos_q))
    else $error("tokens produced without a source beat");

endmodule

@@ hw/rtl/sqt_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sqt_out_fifo: token output queue
// Four-entry queue taking up to two tokens per cycle; one out if not stalled.
// ----------------------------------------------------------------------------
module sqt_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sqt_pkg::push_t  push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sqt_pkg::token_t out_token_o
);

  localparam int DEPTH = sqt_pkg::OUT_DEPTH;
  localparam int PW    = sqt_pkg::OUT_PTR_W;
  localparam int CW    = sqt_pkg::OUT_CNT_W;

  sqt_pkg::token_t mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_token_o = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_nxt      = wr_q + PW'(1);

  // room for two tokens once this cycle's pop is taken into account
  assign room_o = (cnt_q <= CW'(DEPTH - 2)) || ((cnt_q == CW'(DEPTH - 1)) && pop);

  always_comb begin
    wr_d  = wr_q + PW'(push_i.count);
    rd_d  = pop ? (rd_q + PW'(1)) : rd_q;
    cnt_d = cnt_q + CW'(push_i.count) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_nxt] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("output queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o)
    else $error("tokens pushed without room");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd3)
    else $error("more than two tokens in one push");

endmodule

@@ hw/rtl/sql_query_tokenizer.sv @@
// ----------------------------------------------------------------------------
// sql_query_tokenizer: SQL query tokenizer, top level
// Scans query text one byte per beat and produces token beats.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_item_i): one text byte per beat,
// or a beat with end_of_source set that flushes the pending token and adds an
// end token; the position then restarts at zero for the next text.
// Output channel (out_valid_o / out_stall_i / out_token_o): tokens in order;
// last_of_run marks the final token caused by one input beat.
// Throughput: one input beat per cycle. A beat yields two tokens only when it
// closes a pending token and leaves nothing pending, so a run of beats never
// carries more than one token beyond its beat count; the output port, at one
// token per cycle, keeps up and the input is not stalled unless the output is.
// A token passes the input register, then the four-entry output queue that
// the scanner writes, before it is offered.
// A stalled output holds its token; the queue keeps taking beats while two
// slots are free, or one with a token leaving in that cycle, then in_stall_o
// rises.
// Reset clears the scan state, the position and the queue.
// ----------------------------------------------------------------------------
module sql_query_tokenizer #(
  parameter int POSITION_BITS = sqt_pkg::POSITION_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sqt_pkg::source_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sqt_pkg::token_t out_token_o
);

  logic             in_valid_q;
  sqt_pkg::source_t in_q;
  logic             room;
  logic             fire;
  sqt_pkg::push_t   push;

  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  sqt_scanner #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .push_o (push)
  );

  sqt_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_token_o (out_token_o)
  );

endmodule
